// File: rtl/core/vtgd_pkg.sv
`default_nettype none
package vtgd_pkg;

  // Fixed field widths
  localparam int DATA_BITS   = 8;
  localparam int VARINT_BITS = 32;
  localparam int EXTENT_BITS = 17;
  localparam int X_BITS      = 32;
  localparam int Y_BITS      = 33;
  localparam int LEN_BITS    = 24;
  localparam int REPEAT_BITS = 29;
  localparam int CMD_BITS    = 3;
  localparam int MAX_RESULTS = 3;
  localparam int TDATA_BITS  = 96;
  localparam int PAD_BITS    = TDATA_BITS - X_BITS - Y_BITS - LEN_BITS;

  localparam logic [EXTENT_BITS-1:0] EXTENT_RESET = 17'd4096;

  // Command ids
  localparam logic [CMD_BITS-1:0] CMD_MOVE  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LINE  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLOSE = 3'd7;

  // Result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_RING  = 1'b1;

  // Which varint of a command run comes next
  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_DX  = 2'd1,
    PH_DY  = 2'd2
  } phase_t;

  // Finished varint (or bare end of geometry) handed from front to back
  typedef struct packed {
    logic [VARINT_BITS-1:0] value;
    logic                   complete;
    logic                   fin;
  } token_t;

  typedef struct packed {
    logic                kind;
    logic [X_BITS-1:0]   x;
    logic [Y_BITS-1:0]   y;
    logic [LEN_BITS-1:0] len;
    logic                last;
  } result_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// File: rtl/core/vtgd_front.sv
`default_nettype none
module vtgd_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic [vtgd_pkg::DATA_BITS-1:0] in_byte,
  input  wire logic                          in_fin,
  input  wire vtgd_pkg::q_status_t           q_status,
  output logic                               in_ready,
  output logic                               push,
  output vtgd_pkg::token_t                   push_token
);
  import vtgd_pkg::*;

  logic [VARINT_BITS-1:0] varint_value;
  logic [2:0]             varint_shift;
  logic [VARINT_BITS-1:0] contrib;
  logic [VARINT_BITS-1:0] value_now;
  logic                   take;
  logic                   complete;

  assign in_ready = !q_status.full;
  assign take     = in_valid && in_ready;
  assign complete = !in_byte[DATA_BITS-1];

  // Merge seven payload bits; bytes after the fifth add nothing
  always_comb begin
    contrib = '0;
    if (varint_shift < 3'd5) begin
      contrib = VARINT_BITS'(in_byte[DATA_BITS-2:0]) << (6'(varint_shift) * 6'd7);
    end
  end

  assign value_now = varint_value | contrib;

  // Hand over a finished varint or an end of geometry
  assign push                = take && (complete || in_fin);
  assign push_token.value    = value_now;
  assign push_token.complete = complete;
  assign push_token.fin      = in_fin;

  // Accumulate varint bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      varint_value <= '0;
      varint_shift <= '0;
    end else if (take) begin
      if (complete || in_fin) begin
        varint_value <= '0;
        varint_shift <= '0;
      end else begin
        varint_value <= value_now;
        if (varint_shift != 3'd7) begin
          varint_shift <= varint_shift + 3'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vtgd_queue.sv
`default_nettype none
module vtgd_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vtgd_pkg::token_t  push_token,
  input  wire logic              pop,
  output vtgd_pkg::token_t       head,
  output vtgd_pkg::q_status_t    status
);
  import vtgd_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  token_t              entries [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [PTR_BITS:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign status.full  = (fill == (PTR_BITS+1)'(DEPTH));
  assign status.empty = (fill == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entries[rd_ptr];

  // Store incoming tokens
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vtgd_back.sv
`default_nettype none
module vtgd_back #(
  parameter int COORD_BITS      = 32,
  parameter int RING_COUNT_BITS = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [vtgd_pkg::EXTENT_BITS-1:0] cfg_wr_data,
  input  wire vtgd_pkg::token_t                 head,
  input  wire vtgd_pkg::q_status_t              q_status,
  output logic                                  pop,
  output vtgd_pkg::result_t                     out_result,
  output logic                                  out_valid,
  input  wire logic                             out_ready
);
  import vtgd_pkg::*;

  // Flipped y is wide enough for extent minus any signed cursor, up to a 64-bit cap
  localparam int WIDE_Y = ((COORD_BITS > EXTENT_BITS + 1) ? COORD_BITS : EXTENT_BITS + 1) + 1;
  localparam int FY_W   = (WIDE_Y > 64) ? 64 : WIDE_Y;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [FY_W-1:0]            fy_t;
  typedef logic [RING_COUNT_BITS-1:0] rcount_t;

  function automatic logic [VARINT_BITS-1:0] zigzag(input logic [VARINT_BITS-1:0] v);
    zigzag = (v >> 1) ^ {VARINT_BITS{v[0]}};
  endfunction

  function automatic rcount_t ring_inc(input rcount_t c);
    ring_inc = (c != '1) ? c + 1'b1 : c;
  endfunction

  function automatic result_t mk_point(input coord_t px, input fy_t py);
    mk_point.kind = KIND_POINT;
    mk_point.x    = X_BITS'(px);
    mk_point.y    = Y_BITS'(signed'(py));
    mk_point.len  = '0;
    mk_point.last = 1'b0;
  endfunction

  function automatic result_t mk_ring(input rcount_t c);
    mk_ring.kind = KIND_RING;
    mk_ring.x    = '0;
    mk_ring.y    = '0;
    mk_ring.len  = LEN_BITS'(c);
    mk_ring.last = 1'b0;
  endfunction

  // Architectural decode state
  logic [EXTENT_BITS-1:0] tile_extent;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [CMD_BITS-1:0]    command_id;
  logic [REPEAT_BITS-1:0] repeat_left;
  logic [VARINT_BITS-1:0] pending_dx;
  coord_t                 cursor_x;
  coord_t                 cursor_y;
  coord_t                 ring_first_x;
  fy_t                    ring_first_y;
  coord_t                 last_out_x;
  fy_t                    last_out_y;
  rcount_t                ring_count;
  logic                   any_point_seen;

  logic [CMD_BITS-1:0]    command_id_next;
  logic [REPEAT_BITS-1:0] repeat_left_next;
  logic [VARINT_BITS-1:0] pending_dx_next;
  coord_t                 cursor_x_next;
  coord_t                 cursor_y_next;
  coord_t                 ring_first_x_next;
  fy_t                    ring_first_y_next;
  coord_t                 last_out_x_next;
  fy_t                    last_out_y_next;
  rcount_t                ring_count_next;
  logic                   any_point_seen_next;

  // Result buffer feeding the output
  result_t    res_buf [MAX_RESULTS];
  logic [1:0] res_cnt;
  logic [1:0] res_idx;
  result_t    res_new [MAX_RESULTS];
  logic [1:0] n;

  // Datapath terms
  logic [CMD_BITS-1:0]    word_id;
  logic [REPEAT_BITS-1:0] word_cnt;
  logic                   starts_run;
  logic [REPEAT_BITS-1:0] repeat_dec;
  coord_t                 new_x;
  coord_t                 new_y;
  fy_t                    new_fy;
  logic                   take_last;

  assign word_id    = head.value[CMD_BITS-1:0];
  assign word_cnt   = head.value[VARINT_BITS-1:CMD_BITS];
  assign starts_run = ((word_id == CMD_MOVE) || (word_id == CMD_LINE)) && (word_cnt != '0);
  assign repeat_dec = repeat_left - 1'b1;

  // Apply deltas and flip y
  assign new_x  = cursor_x + COORD_BITS'(signed'(zigzag(pending_dx)));
  assign new_y  = cursor_y + COORD_BITS'(signed'(zigzag(head.value)));
  assign new_fy = FY_W'(tile_extent) - FY_W'(signed'(new_y));

  // Pop a token once the previous results are gone or leaving now
  assign out_valid  = (res_idx != res_cnt);
  assign out_result = res_buf[res_idx];
  assign take_last  = out_valid && out_ready && ((res_idx + 2'd1) == res_cnt);
  assign pop        = !q_status.empty && (!out_valid || take_last);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (head.fin) begin
      phase_next = PH_CMD;
    end else if (head.complete) begin
      case (phase)
        PH_CMD:  phase_next = starts_run ? PH_DX : PH_CMD;
        PH_DX:   phase_next = PH_DY;
        default: phase_next = (repeat_dec != '0) ? PH_DX : PH_CMD;
      endcase
    end
  end

  // Execute one token: state update and result list
  always_comb begin
    res_new             = '{default: '0};
    n                   = 2'd0;
    command_id_next     = command_id;
    repeat_left_next    = repeat_left;
    pending_dx_next     = pending_dx;
    cursor_x_next       = cursor_x;
    cursor_y_next       = cursor_y;
    ring_first_x_next   = ring_first_x;
    ring_first_y_next   = ring_first_y;
    last_out_x_next     = last_out_x;
    last_out_y_next     = last_out_y;
    ring_count_next     = ring_count;
    any_point_seen_next = any_point_seen;

    if (head.complete) begin
      case (phase)
        PH_CMD: begin
          command_id_next = word_id;
          if (starts_run) begin
            repeat_left_next = word_cnt;
          end else if ((word_id == CMD_CLOSE) && (ring_count != '0)) begin
            // Repeat the ring's first point, then end the ring
            res_new[n]          = mk_point(ring_first_x, ring_first_y);
            n                   = n + 2'd1;
            res_new[n]          = mk_ring(ring_inc(ring_count));
            n                   = n + 2'd1;
            ring_count_next     = '0;
            any_point_seen_next = 1'b1;
          end
        end
        PH_DX: begin
          pending_dx_next = head.value;
        end
        default: begin
          cursor_x_next = new_x;
          cursor_y_next = new_y;
          // A moveTo ends the ring in progress
          if (command_id == CMD_MOVE) begin
            if (any_point_seen) begin
              res_new[n] = mk_ring(ring_count);
              n          = n + 2'd1;
            end
            ring_count_next = '0;
          end
          // Drop a repeat of the last point in the ring
          if ((ring_count_next == '0) || (new_x != last_out_x) || (new_fy != last_out_y)) begin
            if (ring_count_next == '0) begin
              ring_first_x_next = new_x;
              ring_first_y_next = new_fy;
            end
            res_new[n]          = mk_point(new_x, new_fy);
            n                   = n + 2'd1;
            last_out_x_next     = new_x;
            last_out_y_next     = new_fy;
            ring_count_next     = ring_inc(ring_count_next);
            any_point_seen_next = 1'b1;
          end
          repeat_left_next = repeat_dec;
        end
      endcase
    end

    // End of geometry: close an open ring, return to reset state
    if (head.fin) begin
      if (ring_count_next != '0) begin
        res_new[n] = mk_ring(ring_count_next);
        n          = n + 2'd1;
      end
      command_id_next     = CMD_MOVE;
      repeat_left_next    = '0;
      pending_dx_next     = '0;
      cursor_x_next       = '0;
      cursor_y_next       = '0;
      ring_first_x_next   = '0;
      ring_first_y_next   = '0;
      last_out_x_next     = '0;
      last_out_y_next     = '0;
      ring_count_next     = '0;
      any_point_seen_next = 1'b0;
    end

    if (n != 2'd0) begin
      res_new[n - 2'd1].last = 1'b1;
    end
  end

  // Hold the extent register
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_extent <= EXTENT_RESET;
    end else if (cfg_wr_en) begin
      tile_extent <= cfg_wr_data;
    end
  end

  // Commit decode state on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_CMD;
      command_id     <= CMD_MOVE;
      repeat_left    <= '0;
      pending_dx     <= '0;
      cursor_x       <= '0;
      cursor_y       <= '0;
      ring_first_x   <= '0;
      ring_first_y   <= '0;
      last_out_x     <= '0;
      last_out_y     <= '0;
      ring_count     <= '0;
      any_point_seen <= 1'b0;
    end else if (pop) begin
      phase          <= phase_next;
      command_id     <= command_id_next;
      repeat_left    <= repeat_left_next;
      pending_dx     <= pending_dx_next;
      cursor_x       <= cursor_x_next;
      cursor_y       <= cursor_y_next;
      ring_first_x   <= ring_first_x_next;
      ring_first_y   <= ring_first_y_next;
      last_out_x     <= last_out_x_next;
      last_out_y     <= last_out_y_next;
      ring_count     <= ring_count_next;
      any_point_seen <= any_point_seen_next;
    end
  end

  // Load the result buffer
  always_ff @(posedge clk) begin
    if (pop) begin
      res_buf <= res_new;
    end
  end

  // Step through buffered results one beat at a time
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= '0;
      res_idx <= '0;
    end else if (pop) begin
      res_cnt <= n;
      res_idx <= '0;
    end else if (out_valid && out_ready) begin
      res_idx <= res_idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/vector_tile_geometry_decoder.sv
`default_nettype none
// Vector-tile geometry decoder. Feed the raw bytes of one geometry field, one
// byte per beat on s_axis, with tlast on the final byte; the block decodes the
// varint commands and zigzag deltas and returns points and ring ends on
// m_axis, tlast marking the last result caused by a given input byte. Point
// results carry x and (tile_extent - y); ring results carry the ring's point
// count. Input is taken at one byte per cycle while the token queue has room;
// results leave at one per cycle while m_axis_tready is high, so a byte that
// causes two or three results takes as many output beats, and a four-entry
// token queue between the varint front end and the command executor absorbs
// those bursts before s_axis_tready drops. Tokens and results are registered.
// Write tile_extent only while no geometry is in flight.
module vector_tile_geometry_decoder #(
  parameter int COORD_BITS      = 32,
  parameter int RING_COUNT_BITS = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [vtgd_pkg::EXTENT_BITS-1:0]  cfg_wr_data,   // tile_extent
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [vtgd_pkg::DATA_BITS-1:0]    s_axis_tdata,  // [7:0] data_byte
  input  wire logic                              s_axis_tlast,  // final_byte
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [31:0] point_x, [64:32] point_y, [88:65] ring_length, [95:89] zero
  output logic [vtgd_pkg::TDATA_BITS-1:0]        m_axis_tdata,
  output logic                                   m_axis_tuser,  // kind
  output logic                                   m_axis_tlast   // run_end
);
  import vtgd_pkg::*;

  q_status_t q_status;
  logic      push;
  token_t    push_token;
  logic      pop;
  token_t    head;
  result_t   out_result;

  vtgd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_byte    (s_axis_tdata),
    .in_fin     (s_axis_tlast),
    .q_status   (q_status),
    .in_ready   (s_axis_tready),
    .push       (push),
    .push_token (push_token)
  );

  vtgd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  vtgd_back #(
    .COORD_BITS      (COORD_BITS),
    .RING_COUNT_BITS (RING_COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_result  (out_result),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready)
  );

  // Pack the result beat
  assign m_axis_tdata = {{PAD_BITS{1'b0}}, out_result.len, out_result.y, out_result.x};
  assign m_axis_tuser = out_result.kind;
  assign m_axis_tlast = out_result.last;

endmodule
`default_nettype wire

// File: tb/vector_tile_geometry_decoder_test.sv
`default_nettype none
module vector_tile_geometry_decoder_test;
  import vtgd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  // One input beat, with the results typed in where they are obvious
  typedef struct packed {
    logic [7:0]      data;
    logic            last;
    logic            typed;
    logic [1:0]      nres;
    result_t [2:0]   res;
  } beat_row_t;

  localparam result_t NO_RESULT = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [EXTENT_BITS-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DATA_BITS-1:0] s_axis_tdata = '0;
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [TDATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;

  // Side info for the beat currently on s_axis
  logic beat_typed = 1'b0;
  logic [1:0] beat_nres = '0;
  result_t [2:0] beat_res = '0;

  logic calm = 1'b0;
  int fail_count = 0;
  int stall_cycles = 0;

  result_t expected_q[$];
  beat_row_t dir_rows[$];
  logic [7:0] geo_q[$];

  // Decoder state mirrored by the predictor
  logic [EXTENT_BITS-1:0] extent_q = EXTENT_RESET;
  logic [31:0] acc_value;
  int acc_shift;
  phase_t ph;
  logic [2:0] cmd;
  logic [28:0] reps;
  logic [31:0] held_dx;
  logic [31:0] cur_x, cur_y, first_x, prev_x;
  logic [32:0] first_y, prev_y;
  logic [23:0] ring_len;
  logic drawn;
  result_t step_out [0:2];
  int step_n;

  vector_tile_geometry_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] unzigzag(input logic [31:0] v);
    return (v >> 1) ^ {32{v[0]}};
  endfunction

  function automatic logic [23:0] ring_next(input logic [23:0] c);
    return (c == '1) ? c : c + 24'd1;
  endfunction

  function automatic result_t pt(input logic [31:0] x, input logic [32:0] y, input logic l);
    result_t r;
    r = '0;
    r.kind = KIND_POINT;
    r.x = x;
    r.y = y;
    r.last = l;
    return r;
  endfunction

  function automatic result_t rg(input logic [23:0] len, input logic l);
    result_t r;
    r = '0;
    r.kind = KIND_RING;
    r.len = len;
    r.last = l;
    return r;
  endfunction

  task automatic clear_decoder();
    acc_value = '0;
    acc_shift = 0;
    ph = PH_CMD;
    cmd = CMD_MOVE;
    reps = '0;
    held_dx = '0;
    cur_x = '0;
    cur_y = '0;
    first_x = '0;
    first_y = '0;
    prev_x = '0;
    prev_y = '0;
    ring_len = '0;
    drawn = 1'b0;
  endtask

  task automatic note_result(input logic k, input logic [31:0] x, input logic [32:0] y,
                             input logic [23:0] len);
    step_out[step_n] = '0;
    step_out[step_n].kind = k;
    step_out[step_n].x = x;
    step_out[step_n].y = y;
    step_out[step_n].len = len;
    step_n++;
  endtask

  // Advance the mirrored decoder by one byte; results land in step_out
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [31:0] v;
    logic [32:0] fy;
    step_n = 0;
    if (acc_shift < 5) acc_value = acc_value | ({25'd0, b[6:0]} << (7 * acc_shift));
    if (acc_shift < 7) acc_shift++;
    if (!b[7]) begin
      v = acc_value;
      acc_value = '0;
      acc_shift = 0;
      case (ph)
        PH_CMD: begin
          cmd = v[2:0];
          if ((v[2:0] == CMD_MOVE || v[2:0] == CMD_LINE) && v[31:3] != 0) begin
            reps = v[31:3];
            ph = PH_DX;
          end else if (v[2:0] == CMD_CLOSE && ring_len != 0) begin
            note_result(KIND_POINT, first_x, first_y, '0);
            note_result(KIND_RING, '0, '0, ring_next(ring_len));
            ring_len = '0;
            drawn = 1'b1;
          end
        end
        PH_DX: begin
          held_dx = v;
          ph = PH_DY;
        end
        default: begin
          cur_x = cur_x + unzigzag(held_dx);
          cur_y = cur_y + unzigzag(v);
          fy = {16'd0, extent_q} - {cur_y[31], cur_y};
          // moveTo closes the ring in progress, even an empty one
          if (cmd == CMD_MOVE) begin
            if (drawn) note_result(KIND_RING, '0, '0, ring_len);
            ring_len = '0;
          end
          // drop a repeat of the last point of the ring
          if (ring_len == 0 || cur_x != prev_x || fy != prev_y) begin
            if (ring_len == 0) begin
              first_x = cur_x;
              first_y = fy;
            end
            note_result(KIND_POINT, cur_x, fy, '0);
            prev_x = cur_x;
            prev_y = fy;
            ring_len = ring_next(ring_len);
            drawn = 1'b1;
          end
          reps = reps - 29'd1;
          ph = (reps != 0) ? PH_DX : PH_CMD;
        end
      endcase
    end
    if (fin) begin
      if (ring_len != 0) note_result(KIND_RING, '0, '0, ring_len);
      clear_decoder();
    end
    if (step_n > 0) step_out[step_n-1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [32:0] want, input logic [32:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin : scoreboard
    result_t want;
    int k;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_byte(s_axis_tdata, s_axis_tlast);
        if (beat_typed) begin
          for (k = 0; k < beat_nres; k++) expected_q.insert(expected_q.size(), beat_res[k]);
        end else begin
          for (k = 0; k < step_n; k++) expected_q.insert(expected_q.size(), step_out[k]);
        end
      end
      if (cfg_wr_en) extent_q = cfg_wr_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat expected none got kind %0d x %h y %h len %0d",
                   $time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[64:32],
                   m_axis_tdata[88:65]);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", 33'(want.kind), 33'(m_axis_tuser));
          check_field("point_x", 33'(want.x), 33'(m_axis_tdata[31:0]));
          check_field("point_y", want.y, m_axis_tdata[64:32]);
          check_field("ring_length", 33'(want.len), 33'(m_axis_tdata[88:65]));
          check_field("run_end", 33'(want.last), 33'(m_axis_tlast));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                 $time, stall_cycles, expected_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall at random outside the calm stretch
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 31);
  end

  task automatic send_beat(input beat_row_t row);
    while (!calm && $urandom_range(99) < 31) begin
      @(negedge clk) s_axis_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.data;
    s_axis_tlast <= row.last;
    beat_typed <= row.typed;
    beat_nres <= row.nres;
    beat_res <= row.res;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold the sender until every expected result has come out
  task automatic wait_drained();
    @(negedge clk) s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_extent(input logic [EXTENT_BITS-1:0] v);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk) cfg_wr_en <= 1'b0;
  endtask

  task automatic add_row(input logic [7:0] d, input logic l);
    beat_row_t r;
    r = '0;
    r.data = d;
    r.last = l;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_typed(input logic [7:0] d, input logic l, input logic [1:0] n,
                           input result_t r0, input result_t r1);
    beat_row_t r;
    r = '0;
    r.data = d;
    r.last = l;
    r.typed = 1'b1;
    r.nres = n;
    r.res[0] = r0;
    r.res[1] = r1;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // Varint bytes, now and then padded with redundant continuation bytes
  task automatic put_varint(input logic [31:0] v);
    int len;
    int i;
    logic [31:0] chunk;
    len = 1;
    while (len < 5 && (v >> (7 * len)) != 0) len++;
    if ($urandom_range(9) == 0) len = $urandom_range(8, len);
    for (i = 0; i < len; i++) begin
      chunk = (i < 5) ? (v >> (7 * i)) : $urandom;
      geo_q.insert(geo_q.size(), {(i < len - 1) ? 1'b1 : 1'b0, chunk[6:0]});
    end
  endtask

  task automatic put_delta();
    logic [31:0] d;
    int r;
    r = $urandom_range(99);
    if (r < 15) d = '0;
    else if (r < 65) d = $urandom_range(8) - 4;
    else if (r < 90) d = $urandom_range(65535) - 32768;
    else d = $urandom;
    put_varint((d << 1) ^ {32{d[31]}});
  endtask

  // One geometry: mostly well-formed commands, some noise, some cut short
  task automatic build_geometry();
    int ncmd;
    int k;
    int r;
    int cut;
    logic [28:0] c;
    logic [2:0] id;
    geo_q.delete();
    ncmd = $urandom_range(6, 1);
    for (k = 0; k < ncmd; k++) begin
      r = $urandom_range(99);
      if (r < 25) begin
        c = 29'($urandom_range(3, 1));
        put_varint({c, CMD_MOVE});
        repeat (c) begin
          put_delta();
          put_delta();
        end
      end else if (r < 60) begin
        c = 29'($urandom_range(4, 1));
        put_varint({c, CMD_LINE});
        repeat (c) begin
          put_delta();
          put_delta();
        end
      end else if (r < 75) begin
        c = 29'(($urandom_range(9) == 0) ? $urandom : $urandom_range(3));
        put_varint({c, CMD_CLOSE});
      end else if (r < 87) begin
        id = 3'($urandom_range(7));
        c = (id == CMD_MOVE || id == CMD_LINE) ? '0 : 29'($urandom_range(5));
        put_varint({c, id});
      end else begin
        repeat ($urandom_range(4, 1)) geo_q.insert(geo_q.size(), 8'($urandom));
      end
    end
    if ($urandom_range(9) == 0) begin
      cut = $urandom_range(geo_q.size(), 1);
      while (geo_q.size() > cut) void'(geo_q.pop_back());
    end
  endtask

  task automatic run_phase(input int budget, input bit hold_mid);
    int sent;
    int i;
    beat_row_t r;
    sent = 0;
    while (sent < budget) begin
      build_geometry();
      for (i = 0; i < geo_q.size(); i++) begin
        if (hold_mid && i == geo_q.size() / 2) begin
          wait_drained();
          hold_mid = 1'b0;
        end
        r = '0;
        r.data = geo_q[i];
        r.last = (i == geo_q.size() - 1);
        send_beat(r);
      end
      sent += geo_q.size();
    end
  endtask

  initial begin
    clear_decoder();

    // Directed beats at the reset extent
    add_typed(8'h09, 1'b0, 2'd0, NO_RESULT, NO_RESULT);      // moveTo, one pair
    add_row(8'h02, 1'b0);
    add_typed(8'h04, 1'b0, 2'd1, pt(32'd1, 33'd4094, 1'b1), NO_RESULT);
    add_row(8'h12, 1'b0);                                    // lineTo, two pairs
    add_row(8'h00, 1'b0);
    add_typed(8'h00, 1'b0, 2'd0, NO_RESULT, NO_RESULT);      // repeated point dropped
    add_row(8'h03, 1'b0);
    // dy at the positive extreme, five-byte varint
    add_row(8'hFE, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'hFF, 1'b0);
    add_row(8'h0F, 1'b0);
    add_typed(8'h0F, 1'b0, 2'd2, pt(32'd1, 33'd4094, 1'b0), rg(24'd3, 1'b1));  // closePath
    add_typed(8'h0F, 1'b0, 2'd0, NO_RESULT, NO_RESULT);      // closePath on empty ring
    add_typed(8'h1B, 1'b0, 2'd0, NO_RESULT, NO_RESULT);      // unknown command id
    add_row(8'h01, 1'b0);                                    // moveTo with count zero
    // moveTo word stretched past five bytes
    add_row(8'h89, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h80, 1'b0);
    add_row(8'h7F, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'h01, 1'b1);                                    // ring end, point, ring end
    add_typed(8'h80, 1'b1, 2'd0, NO_RESULT, NO_RESULT);      // last byte, nothing open

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (dir_rows[i]) send_beat(dir_rows[i]);

    // Random geometries across extent settings, extremes included
    set_extent(17'd2);
    run_phase(55, 1'b1);
    set_extent(17'd65536);
    calm = 1'b1;
    run_phase(60, 1'b0);
    calm = 1'b0;
    set_extent(17'd0);
    run_phase(25, 1'b0);
    set_extent(17'd1);
    run_phase(20, 1'b0);
    set_extent(17'd131071);
    run_phase(35, 1'b0);
    set_extent(EXTENT_BITS'($urandom_range(65536, 2)));
    run_phase(30, 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
